/* rtl/sputter_damage_accumulator_top_assert.svh */
// assertion macros for the damage accumulator checker
`ifndef SPUTTER_DAMAGE_ACCUMULATOR_TOP_ASSERT_SVH
`define SPUTTER_DAMAGE_ACCUMULATOR_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define SDA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sda check failed");
// next-cycle implication
`define SDA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sda check failed");
`endif

/* rtl/sda_pkg.sv */
`timescale 1ns / 1ps
package sda_pkg;
  localparam int unsigned DMG_W      = 24;
  localparam logic [23:0] DMG_MAX    = 24'hFFFFFF;
  localparam logic [35:0] E_OFFSET   = 36'd122880;
  localparam logic [35:0] E_CAP      = 36'd1843200;
  localparam logic [16:0] YIELD_ONE  = 17'd65536;
  localparam logic [18:0] YIELD_COEF = 19'd450972;
  localparam logic [1:0]  REG_SCALE  = 2'd0;
  localparam logic [1:0]  REG_ACCEL  = 2'd1;
  localparam logic [1:0]  REG_THRESH = 2'd2;
  localparam logic        OP_HIT     = 1'b0;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_MULP  = 12'b000000000010,
    ST_SQRT  = 12'b000000000100,
    ST_MULA  = 12'b000000001000,
    ST_MULC  = 12'b000000010000,
    ST_MULD  = 12'b000000100000,
    ST_RD    = 12'b000001000000,
    ST_WR    = 12'b000010000000,
    ST_CLR   = 12'b000100000000,
    ST_SWRD  = 12'b001000000000,
    ST_SWCHK = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;
endpackage

/* rtl/sda_ram.sv */
`timescale 1ns / 1ps
module sda_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sputter_damage_accumulator_top.sv */
`timescale 1ns / 1ps
// a load op is taken on accept; a hit runs 4 multiply steps and 24 sqrt steps, then the store read and write
// hit with end of batch adds a sweep over every cell (read, then check and write), then
// the result state, which holds off the next item until the result is taken
// throughput: one item at a time, the next is accepted once the current has finished
// reset: synchronous active low; control and configuration registers reset, then a clearing pass
// writes every cell of both stores before any item is accepted
module sputter_damage_accumulator_top #(
  parameter int GRID_X      = 32,
  parameter int GRID_Y      = 32,
  parameter int TOTAL_CELLS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // op, cell_x, cell_y, cell_z, energy, bound_value
  input  logic        in_tlast,  // end_of_batch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // max_damage
  output logic        out_tuser  // any_removed
);
  import sda_pkg::*;

  localparam int AW    = $clog2(TOTAL_CELLS);
  localparam int INC_W = 29;
  localparam int MW    = INC_W + 1;

  state_t st_r, st_nxt;
  logic [15:0] scale_r;
  logic [19:0] accel_r;
  logic [23:0] thresh_r;

  logic             eob_r, ok_r;
  logic [AW-1:0]    idx_r, addr_r;
  logic [19:0]      energy_r;
  logic [35:0]      a_r;        // excess of the energy product over the offset, zero if none
  logic [47:0]      rem_r;      // sqrt remainder
  logic [47:0]      v_r;        // sqrt radicand
  logic [23:0]      root_r;
  logic [4:0]       step_r;
  logic [37:0]      prod_r;
  logic [16:0]      yield_r;
  logic [INC_W-1:0] inc_r;
  logic             rem_any_r;
  logic [23:0]      maxd_r;
  logic [AW:0]      sw_r;
  logic             res_valid_r, res_rm_r;
  logic [23:0]      res_max_r;

  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [23:0]   ram_wd, ram_rd;

  logic          b_we, b_wd, b_rd;
  logic [AW-1:0] b_wa;

  sda_ram #(.WIDTH(DMG_W), .DEPTH(TOTAL_CELLS)) u_dmg (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  sda_ram #(.WIDTH(1), .DEPTH(TOTAL_CELLS)) u_bound (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
    .raddr(addr_r), .rdata(b_rd)
  );

  // index computation for the incoming item
  logic [4:0]  ix, iy, iz;
  logic [31:0] lin;
  logic        in_ok;
  always_comb begin
    ix = in_tdata[5:1];
    iy = in_tdata[10:6];
    iz = in_tdata[15:11];
    lin = 32'(ix) + 32'(GRID_X) * (32'(iy) + 32'(GRID_Y) * 32'(iz));
    in_ok = (32'(ix) < 32'(GRID_X)) && (32'(iy) < 32'(GRID_Y)) &&
            (lin < 32'(TOTAL_CELLS));
  end

  // one shared multiplier, operands picked by state
  logic [37:0] mul_a;
  logic [23:0] mul_b;
  logic [59:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_MULP: begin mul_a = 38'(energy_r); mul_b = 24'(scale_r); end
      ST_MULA: begin mul_a = 38'(a_r);      mul_b = root_r;       end
      ST_MULC: begin mul_a = prod_r;        mul_b = 24'(YIELD_COEF); end
      ST_MULD: begin mul_a = 38'(yield_r);  mul_b = 24'(accel_r); end
      default: begin mul_a = '0;            mul_b = '0;           end
    endcase
    mul_p = 60'(mul_a) * 60'(mul_b);
  end

  // one restoring sqrt step
  logic [49:0] trial;
  logic [47:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[45:0], v_r[47:46]};
    trial  = {2'b0, rem_sh} - {24'b0, root_r, 2'b01};
  end

  logic [MW-1:0] sum;
  logic          fail;
  assign sum  = MW'(ram_rd) + MW'(inc_r);
  assign fail = b_rd && (ram_rd > thresh_r);

  assign in_tready  = (st_r == ST_IDLE) && !res_valid_r;
  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_max_r;
  assign out_tuser  = res_rm_r;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = addr_r;
    ram_wd = '0;
    ram_ra = addr_r;
    unique case (st_r)
      ST_CLR: ram_we = 1'b1;
      ST_WR: begin
        ram_we = ok_r;
        ram_wd = (sum > MW'(DMG_MAX)) ? DMG_MAX : sum[DMG_W-1:0];
      end
      ST_SWCHK: ram_we = fail;
      default: ram_we = 1'b0;
    endcase
  end

  // bound map: load ops write it on accept, the clearing pass and the sweep clear it
  always_comb begin
    b_we = 1'b0;
    b_wa = addr_r;
    b_wd = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        b_we = in_tvalid && in_tready && (in_tdata[0] != OP_HIT) && in_ok;
        b_wa = lin[AW-1:0];
        b_wd = in_tdata[36];
      end
      ST_CLR:   b_we = 1'b1;
      ST_SWCHK: b_we = fail;
      default:  b_we = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_tvalid && in_tready) st_nxt = (in_tdata[0] == OP_HIT) ? ST_MULP : ST_IDLE;
      ST_MULP:  st_nxt = ST_SQRT;
      ST_SQRT:  if (step_r == 5'd23) st_nxt = ST_MULA;
      ST_MULA:  st_nxt = ST_MULC;
      ST_MULC:  st_nxt = ST_MULD;
      ST_MULD:  st_nxt = ST_RD;
      ST_RD:    st_nxt = ST_WR;
      ST_WR:    st_nxt = eob_r ? ST_SWRD : ST_IDLE;
      ST_CLR:   if (addr_r == AW'(TOTAL_CELLS - 1)) st_nxt = ST_IDLE;
      ST_SWRD:  st_nxt = ST_SWCHK;
      ST_SWCHK: st_nxt = (sw_r == (AW+1)'(TOTAL_CELLS - 1)) ? ST_OUT : ST_SWRD;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      addr_r      <= '0;
      scale_r     <= 16'd256;
      accel_r     <= 20'd256;
      thresh_r    <= 24'd65536;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE:  scale_r  <= cfg_wdata[15:0];
          REG_ACCEL:  accel_r  <= cfg_wdata[19:0];
          REG_THRESH: thresh_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) res_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          energy_r <= in_tdata[35:16];
          eob_r    <= in_tlast;
          ok_r     <= in_ok;
          idx_r    <= lin[AW-1:0];
          addr_r   <= lin[AW-1:0];
        end
        ST_MULP: begin
          a_r <= (mul_p[35:0] > E_OFFSET) ? mul_p[35:0] - E_OFFSET : '0;
          v_r <= {mul_p[35:0] > E_OFFSET ? mul_p[35:0] - E_OFFSET : 36'd0, 12'd0};
          rem_r  <= '0;
          root_r <= '0;
          step_r <= '0;
        end
        ST_SQRT: begin
          step_r <= step_r + 5'd1;
          v_r    <= {v_r[45:0], 2'b00};
          if (!trial[49]) begin
            rem_r  <= trial[47:0];
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[22:0], 1'b0};
          end
        end
        ST_MULA: prod_r <= mul_p[37:0];   // a*r < 2^38 while a is below E_CAP
        ST_MULC: begin
          if (a_r == '0) yield_r <= '0;
          else if (a_r >= E_CAP) yield_r <= YIELD_ONE;
          else if (mul_p[59:40] > 20'(YIELD_ONE)) yield_r <= YIELD_ONE;
          else yield_r <= mul_p[56:40];
        end
        ST_MULD: begin
          inc_r  <= mul_p[INC_W+7:8];
          addr_r <= idx_r;
        end
        ST_WR: begin
          addr_r    <= '0;
          sw_r      <= '0;
          rem_any_r <= 1'b0;
          maxd_r    <= '0;
        end
        ST_CLR: addr_r <= addr_r + AW'(1);
        ST_SWCHK: begin
          if (fail) begin
            rem_any_r <= 1'b1;
          end else if (ram_rd > maxd_r) begin
            maxd_r <= ram_rd;
          end
          sw_r   <= sw_r + (AW+1)'(1);
          addr_r <= addr_r + AW'(1);
        end
        ST_OUT: begin
          res_valid_r <= 1'b1;
          res_rm_r    <= rem_any_r;
          res_max_r   <= maxd_r;
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/sda_checker.sv */
`timescale 1ns / 1ps
`include "sputter_damage_accumulator_top_assert.svh"
module sda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);
  `SDA_ASSERT_NXT(a_busy_after_hit, clk, rst_n, in_tvalid && in_tready, !out_tvalid)
  `SDA_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_tvalid, !in_tready)
  `SDA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
endmodule

bind sputter_damage_accumulator_top sda_checker u_sda_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

/* verif/sputter_damage_accumulator_top_tb.sv */
`timescale 1ns / 1ps
module sputter_damage_accumulator_top_tb;
  import sda_pkg::*;

  localparam int NCELLS = 32768;
  localparam longint CYCLE_LIMIT = 400000000;

  typedef struct {
    bit        op;
    bit [4:0]  x;
    bit [4:0]  y;
    bit [4:0]  z;
    bit [19:0] energy;
    bit        bound;
    bit        last;
  } hit_t;

  typedef struct {
    bit        removed;
    bit [23:0] max_dmg;
  } sweep_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  hit_t      pending_hits[$];
  sweep_t    sweep_results[$];
  bit [23:0] dmg_cells[NCELLS];
  bit        bound_cells[NCELLS];
  bit [15:0] scale_r;
  bit [19:0] accel_r;
  bit [23:0] thresh_r;
  bit        hold;
  bit        calm;
  int        errors;
  longint    cycles;
  hit_t      cur;

  sputter_damage_accumulator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [16:0] sputter_yield(bit [19:0] e);
    bit [63:0] p;
    bit [63:0] a;
    bit [63:0] r;
    bit [63:0] y;
    p = 64'(e) * 64'(scale_r);
    if (p <= 64'(E_OFFSET)) return 0;
    a = p - 64'(E_OFFSET);
    if (a >= 64'(E_CAP)) return YIELD_ONE;
    r = isqrt(a << 12);
    y = (a * r * 64'(YIELD_COEF)) >> 40;
    if (y > 64'(YIELD_ONE)) y = 64'(YIELD_ONE);
    return y[16:0];
  endfunction

  // update the bound or damage map for one accepted item, queue a sweep outcome when a hit ends a batch
  task automatic apply_hit(hit_t h);
    int idx;
    bit [63:0] d;
    sweep_t s;
    idx = int'(h.x) + 32 * (int'(h.y) + 32 * int'(h.z));
    if (h.op != OP_HIT) begin
      bound_cells[idx] = h.bound;
      return;
    end
    d = 64'(dmg_cells[idx]) + ((64'(sputter_yield(h.energy)) * 64'(accel_r)) >> 8);
    dmg_cells[idx] = (d > 64'(DMG_MAX)) ? DMG_MAX : d[23:0];
    if (!h.last) return;
    s.removed = 0;
    s.max_dmg = 0;
    for (int i = 0; i < NCELLS; i++) begin
      if (bound_cells[i] && dmg_cells[i] > thresh_r) begin
        bound_cells[i] = 0;
        dmg_cells[i] = 0;
        s.removed = 1;
      end
      if (dmg_cells[i] > s.max_dmg) s.max_dmg = dmg_cells[i];
    end
    sweep_results.push_back(s);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_hit(cur);
      if (!in_tvalid || in_tready) begin
        if (!hold && pending_hits.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
          cur = pending_hits.pop_front();
          in_tdata <= {3'b000, cur.bound, cur.energy, cur.z, cur.y, cur.x, cur.op};
          in_tlast <= cur.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sweep_results.size() == 0) begin
          $error("unexpected result: any_removed %0b max_damage %0h", out_tuser, out_tdata);
          errors++;
        end else begin
          sweep_t s;
          s = sweep_results.pop_front();
          if (out_tuser !== s.removed) begin
            $error("any_removed: expected %0b, actual %0b", s.removed, out_tuser);
            errors++;
          end
          if (out_tdata !== s.max_dmg) begin
            $error("max_damage: expected %0h, actual %0h", s.max_dmg, out_tdata);
            errors++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCALE:  scale_r = val[15:0];
      REG_ACCEL:  accel_r = val[19:0];
      REG_THRESH: thresh_r = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(bit [15:0] s, bit [19:0] a, bit [23:0] t);
    write_reg(REG_SCALE, 24'(s));
    write_reg(REG_ACCEL, 24'(a));
    write_reg(REG_THRESH, t);
  endtask

  task automatic push_item(bit op, bit [4:0] x, bit [4:0] y, bit [4:0] z,
                           bit [19:0] e, bit b, bit l);
    hit_t h;
    h.op = op; h.x = x; h.y = y; h.z = z; h.energy = e; h.bound = b; h.last = l;
    pending_hits.push_back(h);
  endtask

  // let everything drain, then leave room for a hit still in flight
  task automatic drain();
    hold = 1'b0;
    while (pending_hits.size() > 0 || in_tvalid) @(posedge clk);
    hold = 1'b1;
    while (sweep_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // mostly a small pool of hot cells so that damage builds up and cells fail
  task automatic random_items(int n);
    bit [4:0] px[8];
    bit [4:0] py[8];
    bit [4:0] pz[8];
    int k;
    int sel;
    for (int i = 0; i < 8; i++) begin
      px[i] = 5'($urandom); py[i] = 5'($urandom); pz[i] = 5'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(7);
      sel = $urandom_range(99);
      if (sel < 15)
        push_item(1'b1, px[k], py[k], pz[k], 20'($urandom), $urandom_range(99) < 75,
                  1'($urandom_range(1)));
      else if (sel < 85)
        push_item(OP_HIT, px[k], py[k], pz[k], 20'($urandom), 1'b0,
                  $urandom_range(29) == 0);
      else
        push_item(1'($urandom_range(1)), 5'($urandom), 5'($urandom), 5'($urandom),
                  20'($urandom), 1'($urandom_range(1)), $urandom_range(39) == 0);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold = 1'b1;
    calm = 1'b0;
    scale_r = 256;
    accel_r = 256;
    thresh_r = 65536;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of coordinates and energy, load ops, batch end on a load op
    push_item(1'b1, 5'd0, 5'd0, 5'd0, 20'd0, 1'b1, 1'b0);
    push_item(1'b1, 5'd31, 5'd31, 5'd31, 20'hFFFFF, 1'b1, 1'b1);
    push_item(OP_HIT, 5'd0, 5'd0, 5'd0, 20'hFFFFF, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd0, 5'd0, 5'd0, 20'd480, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd0, 5'd0, 5'd0, 20'd481, 1'b0, 1'b1);
    push_item(OP_HIT, 5'd31, 5'd31, 5'd31, 20'd7680, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd31, 5'd31, 5'd31, 20'd7681, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd31, 5'd31, 5'd31, 20'd1000, 1'b1, 1'b1);
    push_item(1'b1, 5'd31, 5'd31, 5'd31, 20'd0, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd10, 5'd21, 5'd5, 20'd4000, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd0, 5'd0, 5'd0, 20'd0, 1'b0, 1'b1);
    drain();

    // saturating damage, zero scale factor and extreme registers
    set_regs(16'd65535, 20'hFFFFF, 24'hFFFFFF);
    for (int i = 0; i < 3; i++) push_item(OP_HIT, 5'd3, 5'd4, 5'd5, 20'hFFFFF, 1'b0, 1'b0);
    push_item(OP_HIT, 5'd3, 5'd4, 5'd5, 20'hFFFFF, 1'b0, 1'b1);
    drain();
    set_regs(16'd0, 20'd4096, 24'd0);
    push_item(OP_HIT, 5'd7, 5'd7, 5'd7, 20'hFFFFF, 1'b0, 1'b1);
    drain();

    set_regs(16'd256, 20'd256, 24'd65536);
    random_items(300);
    drain();
    set_regs(16'd1, 20'd0, 24'd0);
    random_items(100);
    drain();
    calm = 1'b1;
    set_regs(16'd65535, 20'hFFFFF, 24'hFFFFFF);
    random_items(200);
    drain();
    calm = 1'b0;
    set_regs(16'($urandom_range(65535, 1)), 20'($urandom_range(8192)),
             24'($urandom_range(2000000)));
    random_items(300);
    drain();
    set_regs(16'd300, 20'd512, 24'd200000);
    random_items(250);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sda_pkg.sv
rtl/sda_ram.sv
rtl/sputter_damage_accumulator_top.sv
rtl/sda_checker.sv
verif/sputter_damage_accumulator_top_tb.sv
